// ===== hw/rtl/methylation_context_caller_defines.svh =====
// Assertion macros for the methylation context caller.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef METHYLATION_CONTEXT_CALLER_DEFINES_SVH
`define METHYLATION_CONTEXT_CALLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mcc_pkg.sv =====
// Types and code constants shared by the methylation context caller.
// No dependencies.
`default_nettype none

package mcc_pkg;

  typedef logic [2:0] ref_t;
  typedef logic [3:0] qb_t;
  typedef logic [2:0] call_t;
  typedef logic [2:0] seen_t;

  // reference letters, low three bits of ASCII
  localparam ref_t REF_A = 3'd1;
  localparam ref_t REF_C = 3'd3;
  localparam ref_t REF_T = 3'd4;
  localparam ref_t REF_N = 3'd6;
  localparam ref_t REF_G = 3'd7;

  // packed read bases
  localparam qb_t QB_A = 4'd1;
  localparam qb_t QB_C = 4'd2;
  localparam qb_t QB_G = 4'd4;
  localparam qb_t QB_T = 4'd8;

  // call codes; methylated form is the context plus CALL_METH_OFS
  localparam call_t CALL_NONE     = 3'd0;
  localparam call_t CALL_CHH      = 3'd1;
  localparam call_t CALL_CHG      = 3'd2;
  localparam call_t CALL_CPG      = 3'd3;
  localparam call_t CALL_METH_OFS = 3'd3;

  // first stream index that yields a call
  localparam seen_t CALL_START = 3'd4;

  // everything the context stage needs for one beat
  typedef struct packed {
    logic  emit;
    logic  last;
    logic  strand_ga;
    ref_t  fwd_a;
    ref_t  fwd_b;
    ref_t  fwd_c;
    ref_t  rev_a;
    ref_t  rev_b;
    ref_t  rev_c;
    qb_t   query;
  } win_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcc_if.sv =====
// Valid/ready channel interfaces for the methylation context caller.
// Depends on mcc_pkg.
`default_nettype none

interface mcc_in_if;
  logic              valid;
  logic              ready;
  mcc_pkg::ref_t     ref_code;
  mcc_pkg::qb_t      query_base;
  logic              strand_ga;
  logic              first_item;
  logic              final_item;

  modport source (output valid, ref_code, query_base, strand_ga, first_item, final_item,
                  input ready);
  modport sink (input valid, ref_code, query_base, strand_ga, first_item, final_item,
                output ready);
endinterface

interface mcc_out_if;
  logic              valid;
  logic              ready;
  mcc_pkg::call_t    call_code;
  logic              last_call;

  modport source (output valid, call_code, last_call, input ready);
  modport sink (input valid, call_code, last_call, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mcc_window.sv =====
// Reference window, query delay line and read position tracking.
// Depends on mcc_pkg and methylation_context_caller_defines.svh.
`default_nettype none

`include "methylation_context_caller_defines.svh"

module mcc_window (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire mcc_pkg::ref_t      ref_code,
  input  wire mcc_pkg::qb_t       query_base,
  input  wire logic               strand_ga,
  input  wire logic               first_item,
  input  wire logic               final_item,
  output mcc_pkg::win_view_t      view
);
  import mcc_pkg::*;

  ref_t  win_r [4];
  qb_t   qdly_r [2];
  seen_t seen_r, seen_nxt;
  logic  strand_r, strand_nxt;
  seen_t seen_eff;

  always_comb begin
    seen_eff   = first_item ? '0 : seen_r;
    strand_nxt = (seen_eff == '0) ? strand_ga : strand_r;
    if (final_item) begin
      seen_nxt = '0;
    end else if (seen_eff < CALL_START) begin
      seen_nxt = seen_eff + 3'd1;
    end else begin
      seen_nxt = seen_eff;
    end
  end

  always_comb begin
    view.emit      = (seen_eff >= CALL_START);
    view.last      = final_item;
    view.strand_ga = strand_nxt;
    view.fwd_a     = win_r[1];
    view.fwd_b     = win_r[0];
    view.fwd_c     = ref_code;
    view.rev_a     = win_r[3];
    view.rev_b     = win_r[2];
    view.rev_c     = win_r[1];
    view.query     = qdly_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      strand_r <= 1'b0;
      win_r    <= '{default: '0};
      qdly_r   <= '{default: '0};
    end else if (accept) begin
      seen_r    <= seen_nxt;
      strand_r  <= strand_nxt;
      win_r[3]  <= win_r[2];
      win_r[2]  <= win_r[1];
      win_r[1]  <= win_r[0];
      win_r[0]  <= ref_code;
      qdly_r[1] <= qdly_r[0];
      qdly_r[0] <= query_base;
    end
  end

  `MCC_ASSERT_NOW(a_seen_range, clk, rst_n, 1'b1, seen_r <= CALL_START, "read position overran")
  `MCC_ASSERT_NEXT(a_final_clears, clk, rst_n, accept && final_item, seen_r == '0,
                   "final beat did not end the read")
  `MCC_ASSERT_NEXT(a_first_restarts, clk, rst_n, accept && first_item && !final_item,
                   seen_r == 3'd1, "first beat did not restart the read")

endmodule

`default_nettype wire

// ===== hw/rtl/mcc_ctx.sv =====
// Cytosine context lookup and methylation call for one window view.
// Depends on mcc_pkg.
`default_nettype none

module mcc_ctx (
  input  wire mcc_pkg::win_view_t view,
  output mcc_pkg::call_t          call_code
);
  import mcc_pkg::*;

  function automatic logic non_g(input ref_t v);
    non_g = (v == REF_A) || (v == REF_C) || (v == REF_T) || (v == REF_N);
  endfunction

  function automatic call_t ctx_forward(input ref_t a, input ref_t b, input ref_t c);
    call_t r;
    r = CALL_NONE;
    if (a == REF_C) begin
      if (non_g(b)) begin
        if (non_g(c)) r = CALL_CHH;
        else if (c == REF_G) r = CALL_CHG;
      end else if (b == REF_G && (non_g(c) || c == REF_G)) begin
        r = CALL_CPG;
      end
    end
    return r;
  endfunction

  function automatic call_t ctx_reverse(input ref_t a, input ref_t b, input ref_t c);
    call_t r;
    r = CALL_NONE;
    if (c == REF_G && (non_g(a) || a == REF_G)) begin
      if (b == REF_C) r = CALL_CPG;
      else if (b == REF_A || b == REF_T || b == REF_N || b == REF_G)
        r = (a == REF_C) ? CALL_CHG : CALL_CHH;
    end
    return r;
  endfunction

  call_t ctx;
  qb_t   meth_base;
  qb_t   unme_base;

  always_comb begin
    ctx = view.strand_ga ? ctx_reverse(view.rev_a, view.rev_b, view.rev_c)
                         : ctx_forward(view.fwd_a, view.fwd_b, view.fwd_c);
    meth_base = view.strand_ga ? QB_G : QB_C;
    unme_base = view.strand_ga ? QB_A : QB_T;
    call_code = ctx;
    if (ctx != CALL_NONE) begin
      if (view.query == meth_base) call_code = ctx + CALL_METH_OFS;
      else if (view.query != unme_base) call_code = CALL_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/methylation_context_caller.sv =====
// Methylation context caller: one call per query position, third to third-last of a read.
// Calls are registered and leave in the cycle after the beat that completes them.
// Throughput: one beat per cycle; input stalls only while a held result is not taken.
// Reset (synchronous, active low) clears the window, delay line, position and result valid.
// Top level; depends on mcc_pkg, mcc_if, mcc_window and mcc_ctx.
`default_nettype none

module methylation_context_caller (
  input  wire logic clk,
  input  wire logic rst_n,
  mcc_in_if.sink    in_ch,
  mcc_out_if.source out_ch
);
  import mcc_pkg::*;

  win_view_t view;
  call_t     call_code;
  logic      accept;
  logic      out_valid_r;
  call_t     out_code_r;
  logic      out_last_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  mcc_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .ref_code   (in_ch.ref_code),
    .query_base (in_ch.query_base),
    .strand_ga  (in_ch.strand_ga),
    .first_item (in_ch.first_item),
    .final_item (in_ch.final_item),
    .view       (view)
  );

  mcc_ctx u_ctx (
    .view      (view),
    .call_code (call_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= view.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads only on a beat that yields a call
  always_ff @(posedge clk) begin
    if (accept && view.emit) begin
      out_code_r <= call_code;
      out_last_r <= view.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.call_code = out_code_r;
  assign out_ch.last_call = out_last_r;

endmodule

`default_nettype wire
